>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/chte_pkg.sv
package chte_pkg;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_INSERT = 2'd1;
  localparam action_t ACT_REMOVE = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

  localparam int BUCKETS_DEF   = 1024;
  localparam int WAYS_DEF      = 4;
  localparam int KEY_BYTES_DEF = 8;

  localparam int SUM_W = 11;
  localparam logic [SUM_W-1:0] HASH_MOD = 11'd1001;

  localparam int KEY_W   = 64;
  localparam int KLEN_W  = 4;
  localparam int VALUE_W = 32;

endpackage

>>> rtl/chained_hash_table_engine_top.sv
// Key/value store with one bucket per key and WAYS slots per bucket.
// Input channel (in_valid/in_ready) carries one request word: action
// (lookup, insert or update, remove), a key of up to KEY_BYTES bytes with
// its length, and a value. Output channel (out_valid/out_ready) returns one
// word per request: the looked-up value and a status (found or done,
// not found, bucket full).
// The bucket is the byte sum of the key modulo 1001. One byte adder sums
// the key a byte a cycle, a compare-subtract reduces the sum, one bucket
// row is read from the table memory, one comparator walks the ways, and
// the row is written back.
// Only one request is in flight: the next request is taken once the
// engine has finished write-back and returned to idle.
// After reset the table runs a clearing pass over all BUCKETS rows, one
// row a cycle, with in_ready low.
// When the receiver stalls, the finished word holds in the output register;
// a following request is accepted and processed, then waits at write-back
// until the held word is taken.
`include "assert_macros.svh"

module chained_hash_table_engine_top #(
  parameter int BUCKETS   = chte_pkg::BUCKETS_DEF,
  parameter int WAYS      = chte_pkg::WAYS_DEF,
  parameter int KEY_BYTES = chte_pkg::KEY_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_action,
  input  logic [chte_pkg::KEY_W-1:0]            in_key_bytes,
  input  logic [chte_pkg::KLEN_W-1:0]           in_key_length,
  input  logic signed [chte_pkg::VALUE_W-1:0]   in_value_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [chte_pkg::VALUE_W-1:0]   out_value_out,
  output logic [1:0]                            out_status
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int VW = chte_pkg::VALUE_W;
  localparam int LW = chte_pkg::KLEN_W;
  localparam int EW = 1 + LW + KW + VW;
  localparam int RW = WAYS * EW;
  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SW = chte_pkg::SUM_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;

  logic [RW-1:0] mem [BUCKETS];

  logic [2:0]              state_r;
  logic [BW-1:0]           clr_cnt_r;
  chte_pkg::action_t       action_r;
  logic [LW-1:0]           len_r;
  logic [KW-1:0]           key_r;
  logic [KW-1:0]           sh_r;
  logic [VW-1:0]           val_r;
  logic [LW-1:0]           cnt_r;
  logic [SW-1:0]           sum_r;
  logic [RW-1:0]           row_r;
  logic [WW-1:0]           way_r;
  logic                    hit_r;
  logic                    free_r;
  logic [WW-1:0]           hit_w_r;
  logic [WW-1:0]           free_w_r;
  logic [VW-1:0]           hit_val_r;
  logic                    out_valid_r;
  logic [VW-1:0]           out_value_r;
  chte_pkg::status_t       out_status_r;

  logic [LW-1:0]           len_c;
  logic [chte_pkg::KEY_W-1:0] key_c;
  logic [EW-1:0]           ent;
  logic                    ent_valid;
  logic [LW-1:0]           ent_len;
  logic [KW-1:0]           ent_key;
  logic [VW-1:0]           ent_val;
  logic                    finish;
  logic                    wr_en;
  logic [BW-1:0]           wr_addr;
  logic [RW-1:0]           wr_data;
  logic [WW-1:0]           wb_way;
  logic                    is_ins;
  logic [VW-1:0]           res_value;
  chte_pkg::status_t       res_status;
  logic                    accept;

  assign in_ready      = (state_r == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  always_comb begin
    len_c = (in_key_length > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : in_key_length;
    for (int i = 0; i < 8; i++) begin
      key_c[8*i +: 8] = (LW'(i) < len_c) ? in_key_bytes[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    ent       = row_r[way_r*EW +: EW];
    ent_valid = ent[EW-1];
    ent_len   = ent[EW-2 -: LW];
    ent_key   = ent[VW +: KW];
    ent_val   = ent[VW-1:0];
  end

  always_comb begin
    is_ins = (action_r == chte_pkg::ACT_INSERT);
    wb_way = hit_r ? hit_w_r : free_w_r;
    finish = (state_r == S_WB) && (!out_valid_r || out_ready);
    res_value  = '0;
    res_status = chte_pkg::ST_OK;
    case (action_r)
      chte_pkg::ACT_LOOKUP: begin
        if (hit_r) res_value = hit_val_r;
        else       res_status = chte_pkg::ST_NOTFOUND;
      end
      chte_pkg::ACT_INSERT: begin
        if (!hit_r && !free_r) res_status = chte_pkg::ST_FULL;
      end
      chte_pkg::ACT_REMOVE: begin
        if (!hit_r) res_status = chte_pkg::ST_NOTFOUND;
      end
      default: begin
        res_status = chte_pkg::ST_OK;
      end
    endcase
    wr_data = row_r;
    wr_data[wb_way*EW +: EW] = {is_ins, len_r, key_r, val_r};
    wr_addr = BW'(sum_r);
    wr_en   = finish && ((is_ins && (hit_r || free_r)) ||
              ((action_r == chte_pkg::ACT_REMOVE) && hit_r));
    if (state_r == S_CLR) begin
      wr_data = '0;
      wr_addr = clr_cnt_r;
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_r == S_RD) begin
      row_r <= mem[BW'(sum_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      len_r    <= len_c;
      key_r    <= key_c[KW-1:0];
      sh_r     <= key_c[KW-1:0];
      val_r    <= in_value_in;
      cnt_r    <= '0;
      sum_r    <= '0;
    end
    case (state_r)
      S_SUM: begin
        if (cnt_r != len_r) begin
          sum_r <= sum_r + SW'(sh_r[7:0]);
          sh_r  <= sh_r >> 8;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_MOD: begin
        if (sum_r >= chte_pkg::HASH_MOD) sum_r <= sum_r - chte_pkg::HASH_MOD;
      end
      S_RD: begin
        way_r    <= '0;
        hit_r    <= 1'b0;
        free_r   <= 1'b0;
        hit_w_r  <= '0;
        free_w_r <= '0;
      end
      S_SCAN: begin
        if (ent_valid) begin
          if (!hit_r && ent_len == len_r && ent_key == key_r) begin
            hit_r     <= 1'b1;
            hit_w_r   <= way_r;
            hit_val_r <= ent_val;
          end
        end else if (!free_r) begin
          free_r   <= 1'b1;
          free_w_r <= way_r;
        end
        way_r <= way_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (finish) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (finish) out_valid_r <= 1'b1;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == BW'(BUCKETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state_r <= S_SUM;
        end
        S_SUM: begin
          if (cnt_r == len_r) state_r <= S_MOD;
        end
        S_MOD: begin
          if (sum_r < chte_pkg::HASH_MOD) state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (way_r == WW'(WAYS - 1)) state_r <= S_WB;
        end
        S_WB: begin
          if (finish) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_bucket_range, clk, rst_n, (state_r == S_SCAN),
    (sum_r < chte_pkg::HASH_MOD), "bucket index out of range during scan")
  `ASSERT_IMPLIES(a_lookup_no_write, clk, rst_n, (wr_en && state_r == S_WB),
    (action_r == chte_pkg::ACT_INSERT || action_r == chte_pkg::ACT_REMOVE),
    "table written by a lookup")
  `ASSERT_IMPLIES(a_full_zero, clk, rst_n,
    (out_valid_r && out_status_r == chte_pkg::ST_FULL), (out_value_r == '0),
    "bucket full word carries a value")
  `ASSERT_NEXT(a_accept_sum, clk, rst_n, (in_valid && in_ready),
    (state_r == S_SUM && !in_ready), "accepted word did not start the key sum")

endmodule
